[design/itf_pkg.sv]
// Shared types, constants and helpers for the integer to text formatter.
`timescale 1ns / 1ps

package itf_pkg;

    // Operand and digit buffer sizes
    localparam int C_VAL_W  = 32;
    localparam int C_DEC_N  = 10;              // decimal digits of a 32-bit value
    localparam int C_HEX_N  = C_VAL_W / 4;     // hex digits of a 32-bit value
    localparam int C_BCD_W  = 4 * C_DEC_N;
    localparam int C_CNT_W  = $clog2(C_VAL_W);

    // Mode codes
    localparam logic [1:0] C_MODE_SDEC = 2'd0;
    localparam logic [1:0] C_MODE_UDEC = 2'd1;
    localparam logic [1:0] C_MODE_HEXL = 2'd2;
    localparam logic [1:0] C_MODE_HEXU = 2'd3;

    // ASCII codes
    localparam logic [7:0] C_CH_MINUS = 8'h2D;
    localparam logic [7:0] C_CH_SPACE = 8'h20;
    localparam logic [7:0] C_CH_ZERO  = 8'h30;
    localparam logic [7:0] C_CH_UPA   = 8'h41;
    localparam logic [7:0] C_CH_LOWA  = 8'h61;

    // Request to the binary to BCD engine
    typedef struct packed {
        logic               start;
        logic [C_VAL_W-1:0] value;
    } t_bcd_req;

    // Response from the binary to BCD engine
    typedef struct packed {
        logic               done;
        logic [C_BCD_W-1:0] bcd;
    } t_bcd_rsp;

    // One digit nibble to its ASCII character
    function automatic logic [7:0] f_digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] ext;
        ext = {4'd0, nib};
        if (nib < 4'd10) begin
            f_digit_char = C_CH_ZERO + ext;
        end else if (upper) begin
            f_digit_char = C_CH_UPA + ext - 8'd10;
        end else begin
            f_digit_char = C_CH_LOWA + ext - 8'd10;
        end
    endfunction

endpackage

[design/itf_bcd.sv]
// Iterative binary to BCD converter, shift-and-add-3, one bit per cycle.
`timescale 1ns / 1ps

module itf_bcd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itf_pkg::t_bcd_req i_req,
    output itf_pkg::t_bcd_rsp o_rsp
);
    import itf_pkg::*;

    logic [C_VAL_W-1:0] r_bin, n_bin;
    logic [C_BCD_W-1:0] r_bcd, n_bcd;
    logic [C_CNT_W-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [C_BCD_W-1:0] adj;

    // Add 3 to every nibble that is 5 or more
    always_comb begin
        for (int d = 0; d < C_DEC_N; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // Step control
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_bin  = i_req.value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            {n_bcd, n_bin} = {adj[C_BCD_W-2:0], r_bin, 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == C_CNT_W'(C_VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.bcd  = r_bcd;

endmodule

[design/integer_to_text_formatter.sv]
// Top level: formats a 32-bit integer as ASCII text, several characters per request.
// Decimal: BCD conversion, then handoff to trimming; hex goes straight to trimming. Leading
// zero digits are trimmed (1 to 10 decimal or 1 to 8 hex digits kept), a setup step sizes
// the padding, then one character per cycle unless stalled: max(text length, width) in all.
// One value at a time; the input stalls until its last character is registered.
// Reset (synchronous, active low) clears control state only.
`timescale 1ns / 1ps

module integer_to_text_formatter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [itf_pkg::C_VAL_W-1:0] i_value,
    input  logic [1:0]                  i_mode,
    input  logic [5:0]                  i_field_width,
    input  logic                        i_left_align,
    input  logic                        i_zero_pad,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_character,
    output logic                        o_last
);
    import itf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_TRIM  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [5:0]         r_width, n_width;
    logic               r_left, n_left;
    logic               r_zeros, n_zeros;
    logic               r_neg, n_neg;
    logic [C_BCD_W-1:0] r_dig, n_dig;
    logic [3:0]         r_nd, n_nd;
    logic [5:0]         r_pad, n_pad;
    logic [5:0]         r_total, n_total;
    logic [5:0]         r_k, n_k;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_char, n_char;
    logic               r_last, n_last;

    t_bcd_req           bcd_req;
    t_bcd_rsp           bcd_rsp;
    logic               accept;
    logic               out_free;
    logic [C_VAL_W-1:0] mag;
    logic [5:0]         len6;
    logic [6:0]         k7, s7, nd7, pad7;
    logic [7:0]         ch;
    logic               is_dig;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_stall;

    // Magnitude of the operand
    assign mag = (i_mode == C_MODE_SDEC && i_value[C_VAL_W-1]) ? (C_VAL_W'(0) - i_value)
                                                                : i_value;

    assign bcd_req.start = accept && (i_mode == C_MODE_SDEC || i_mode == C_MODE_UDEC);
    assign bcd_req.value = mag;

    itf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bcd_req),
        .o_rsp   (bcd_rsp)
    );

    // Text length: digits plus sign
    assign len6 = {2'd0, r_nd} + {5'd0, r_neg};

    // Character at the current position
    assign k7   = {1'b0, r_k};
    assign s7   = {6'd0, r_neg};
    assign nd7  = {3'd0, r_nd};
    assign pad7 = {1'b0, r_pad};

    always_comb begin
        ch     = C_CH_SPACE;
        is_dig = 1'b0;
        if (r_left) begin
            if (k7 < s7) begin
                ch = C_CH_MINUS;
            end else if (k7 < s7 + nd7) begin
                is_dig = 1'b1;
            end else begin
                ch = C_CH_SPACE;
            end
        end else if (r_zeros) begin
            if (k7 < s7) begin
                ch = C_CH_MINUS;
            end else if (k7 < s7 + pad7) begin
                ch = C_CH_ZERO;
            end else begin
                is_dig = 1'b1;
            end
        end else begin
            if (k7 < pad7) begin
                ch = C_CH_SPACE;
            end else if (k7 < pad7 + s7) begin
                ch = C_CH_MINUS;
            end else begin
                is_dig = 1'b1;
            end
        end
        if (is_dig) begin
            ch = f_digit_char(r_dig[C_BCD_W-1 -: 4], r_mode == C_MODE_HEXU);
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_width  = r_width;
        n_left   = r_left;
        n_zeros  = r_zeros;
        n_neg    = r_neg;
        n_dig    = r_dig;
        n_nd     = r_nd;
        n_pad    = r_pad;
        n_total  = r_total;
        n_k      = r_k;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;

        // Output register drains when taken
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode  = i_mode;
                    n_width = i_field_width;
                    n_left  = i_left_align;
                    n_zeros = i_zero_pad;
                    n_neg   = (i_mode == C_MODE_SDEC) && i_value[C_VAL_W-1];
                    if (i_mode == C_MODE_SDEC || i_mode == C_MODE_UDEC) begin
                        n_state = S_CONV;
                    end else begin
                        n_dig   = {i_value, {(C_BCD_W - C_VAL_W){1'b0}}};
                        n_nd    = 4'(C_HEX_N);
                        n_state = S_TRIM;
                    end
                end
            end
            S_CONV: begin
                if (bcd_rsp.done) begin
                    n_dig   = bcd_rsp.bcd;
                    n_nd    = 4'(C_DEC_N);
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                // Drop one leading zero digit per cycle, keep at least one
                if (r_dig[C_BCD_W-1 -: 4] == 4'd0 && r_nd > 4'd1) begin
                    n_dig = {r_dig[C_BCD_W-5:0], 4'd0};
                    n_nd  = r_nd - 4'd1;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_width > len6) begin
                    n_pad   = r_width - len6;
                    n_total = r_width;
                end else begin
                    n_pad   = '0;
                    n_total = len6;
                end
                n_k     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = ch;
                    n_last   = (r_k == r_total - 6'd1);
                    n_k      = r_k + 6'd1;
                    if (is_dig) begin
                        n_dig = {r_dig[C_BCD_W-5:0], 4'd0};
                    end
                    if (r_k == r_total - 6'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_mode  <= n_mode;
        r_width <= n_width;
        r_left  <= n_left;
        r_zeros <= n_zeros;
        r_neg   <= n_neg;
        r_dig   <= n_dig;
        r_nd    <= n_nd;
        r_pad   <= n_pad;
        r_total <= n_total;
        r_k     <= n_k;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
